>>> rtl/kqsb_pkg.sv
`default_nettype none

package kqsb_pkg;

	localparam int QNUM_W = 4;
	localparam int DATA_W = 32;

	// request kinds
	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	// response status codes
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic                     req_type;
		logic [QNUM_W-1:0]        queue_num;
		logic signed [DATA_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data_out;
		logic [1:0]               status;
	} rsp_t;

endpackage

`default_nettype wire

>>> rtl/kqsb_mem.sv
`default_nettype none

// simple dual-port RAM, one write and one registered read per cycle
module kqsb_mem #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/k_queues_shared_buffer.sv
`default_nettype none

// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_ready  kqsb_pkg::req_t  {req_type, queue_num, data_in}
// rsp      out  rsp_valid/rsp_ready  kqsb_pkg::rsp_t  {data_out, status}
//
// Steps: enqueue reads the queue table and free-slot link, then updates;
// dequeue reads the queue table, then the head slot link/data, then writes back;
// rejected / full / empty requests are answered from idle. The chain of dependent RAM reads sets this.
// One request in flight; a new request is taken while the last response waits.
// Reset (arst_n low) empties all queues and puts every slot on the free list;
// no clearing pass, untouched slots are tracked with a fill count.
// A stalled rsp holds; the block parks a finished response until rsp drains.
module k_queues_shared_buffer #(
	parameter int SLOTS  = 16,
	parameter int QUEUES = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire kqsb_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output kqsb_pkg::rsp_t      rsp
);

	import kqsb_pkg::*;

	// SW indexes a slot, PW also holds the null pointer (== SLOTS)
	localparam int SW = $clog2(SLOTS);
	localparam int PW = $clog2(SLOTS + 1);
	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam logic [PW-1:0] NULL_PTR = PW'(SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ,
		ST_DEQ_RD,
		ST_DEQ_WB,
		ST_POST
	} state_t;

	state_t           state_q;
	logic [QW-1:0]    q_q;
	logic [DATA_W-1:0] data_q;
	logic [PW-1:0]    free_head_q;
	logic [PW-1:0]    fill_q;       // slots at or above this were never allocated
	logic [QUEUES-1:0] head_vld_q;  // queue non-empty
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	// queue table entry: {head, tail}
	logic             qt_we;
	logic [QW-1:0]    qt_raddr;
	logic [2*SW-1:0]  qt_wdata;
	logic [2*SW-1:0]  qt_rdata;
	logic [SW-1:0]    q_head;
	logic [SW-1:0]    q_tail;

	logic             lk_we;
	logic [SW-1:0]    lk_waddr;
	logic [PW-1:0]    lk_wdata;
	logic [SW-1:0]    lk_raddr;
	logic [PW-1:0]    lk_rdata;

	logic             dt_we;
	logic [DATA_W-1:0] dt_rdata;

	logic [QNUM_W-1:0] qn;
	logic             q_in_rng;
	logic [QW-1:0]    qidx_in;
	logic             free_null;
	logic [SW-1:0]    slot;
	logic [PW-1:0]    nxt_free;
	logic             is_enq;
	logic             reject;
	logic             fin;
	rsp_t             fin_res;
	logic             out_free;

	always_comb begin
		qn        = req.queue_num;
		q_in_rng  = (qn != '0) && (32'(qn) <= 32'(QUEUES));
		qidx_in   = QW'(qn - QNUM_W'(1));
		is_enq    = (req.req_type == REQ_ENQ);
		free_null = (free_head_q >= NULL_PTR);
		reject    = !q_in_rng || (is_enq && free_null) ||
			(!is_enq && !head_vld_q[qidx_in]);
		q_head    = qt_rdata[2*SW-1:SW];
		q_tail    = qt_rdata[SW-1:0];
		slot      = free_head_q[SW-1:0];
		// untouched slots still chain to their successor
		nxt_free  = (free_head_q < fill_q) ? lk_rdata : free_head_q + PW'(1);
		out_free  = !rsp_valid_q || rsp_ready;

		qt_raddr  = (state_q == ST_IDLE) ? qidx_in : q_q;
		lk_raddr  = (state_q == ST_DEQ_RD) ? q_head : slot;

		qt_we     = 1'b0;
		qt_wdata  = {q_head, slot};
		lk_we     = 1'b0;
		lk_waddr  = q_tail;
		lk_wdata  = PW'(slot);
		dt_we     = 1'b0;
		fin       = 1'b0;
		fin_res   = '{data_out: '0, status: STAT_DONE};

		unique case (state_q)
			ST_IDLE: begin
				fin             = req_valid && reject;
				fin_res.status  = is_enq ? STAT_FULL : STAT_EMPTY;
			end
			ST_ENQ: begin
				// new slot becomes tail; link it behind the old tail if any
				qt_we    = 1'b1;
				qt_wdata = {head_vld_q[q_q] ? q_head : slot, slot};
				lk_we    = head_vld_q[q_q];
				dt_we    = 1'b1;
				fin      = 1'b1;
			end
			ST_DEQ_RD: begin
			end
			ST_DEQ_WB: begin
				// last element leaves: just drop the valid bit
				qt_we            = (q_head != q_tail);
				qt_wdata         = {lk_rdata[SW-1:0], q_tail};
				lk_we            = 1'b1;
				lk_waddr         = q_head;
				lk_wdata         = free_head_q;
				fin              = 1'b1;
				fin_res.data_out = dt_rdata;
			end
			ST_POST: begin
			end
			default: begin
			end
		endcase
	end

	kqsb_mem #(.WIDTH(2*SW), .DEPTH(QUEUES)) u_qtab (
		.clk   (clk),
		.we    (qt_we),
		.waddr (q_q),
		.wdata (qt_wdata),
		.raddr (qt_raddr),
		.rdata (qt_rdata)
	);

	kqsb_mem #(.WIDTH(PW), .DEPTH(SLOTS)) u_link (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.raddr (lk_raddr),
		.rdata (lk_rdata)
	);

	kqsb_mem #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_data (
		.clk   (clk),
		.we    (dt_we),
		.waddr (slot),
		.wdata (data_q),
		.raddr (q_head),
		.rdata (dt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			q_q         <= '0;
			data_q      <= '0;
			free_head_q <= '0;
			fill_q      <= '0;
			head_vld_q  <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// drained and nothing new loaded this cycle
			if (rsp_valid_q && rsp_ready && !fin && state_q != ST_POST) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						q_q    <= qidx_in;
						data_q <= req.data_in;
						if (!reject) begin
							state_q <= is_enq ? ST_ENQ : ST_DEQ_RD;
						end
					end
				end
				ST_ENQ: begin
					free_head_q       <= nxt_free;
					head_vld_q[q_q]   <= 1'b1;
					if (free_head_q == fill_q) begin
						fill_q <= fill_q + PW'(1);
					end
				end
				ST_DEQ_RD: begin
					state_q <= ST_DEQ_WB;
				end
				ST_DEQ_WB: begin
					free_head_q <= PW'(q_head);
					if (q_head == q_tail) begin
						head_vld_q[q_q] <= 1'b0;
					end
				end
				ST_POST: begin
					if (out_free) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// park the response if the output register is still occupied
			if (fin) begin
				if (out_free) begin
					rsp_q       <= fin_res;
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end else begin
					res_q   <= fin_res;
					state_q <= ST_POST;
				end
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> dv/k_queues_shared_buffer_test.sv
`timescale 1ns / 100ps

module k_queues_shared_buffer_test;
	import kqsb_pkg::*;

	localparam int SLOTS  = 16;
	localparam int QUEUES = 8;
	localparam int PTR_W  = $clog2(SLOTS + 1);	// room for the null value SLOTS
	localparam logic [PTR_W-1:0] NULL_SLOT = PTR_W'(SLOTS);

	// one pending request; settle makes the driver hold it back until the
	// block has returned every response it owes
	typedef struct {
		req_t r;
		bit   settle;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// shadow of the block: queue heads and tails, slot links, slot words
	logic [PTR_W-1:0]  q_head [QUEUES];
	logic [PTR_W-1:0]  q_tail [QUEUES];
	logic [PTR_W-1:0]  slot_next [SLOTS];
	logic [DATA_W-1:0] slot_word [SLOTS];
	logic [PTR_W-1:0]  free_slot;

	stim_t pending[$];	// requests not yet offered
	rsp_t  owed_rsps[$];	// responses owed, oldest first

	// rough occupancy, tracked while building stimulus only, to steer bursts
	int fill_level [16];
	int slots_taken;

	int  reqs_taken;
	int  errors;
	int  hold_left;
	bit  held_once;
	bit  calm;

	k_queues_shared_buffer #(
		.SLOTS(SLOTS),
		.QUEUES(QUEUES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	// no random idling on either side for a stretch in the middle of the run
	assign calm = reqs_taken >= 600 && reqs_taken < 950;

	// Shadow update for one accepted request; returns the response it owes.
	function automatic rsp_t serve_request(req_t r);
		rsp_t             o;
		int               q;
		logic [PTR_W-1:0] s;
		o.data_out = '0;
		o.status   = STAT_DONE;
		if (r.queue_num == 0 || r.queue_num > QUEUES) begin
			// bad queue number: rejected, nothing moves
			o.status = (r.req_type == REQ_DEQ) ? STAT_EMPTY : STAT_FULL;
		end else if (r.req_type == REQ_ENQ) begin
			q = r.queue_num - 1;
			s = free_slot;
			if (s >= SLOTS) begin
				o.status = STAT_FULL;
			end else begin
				free_slot = slot_next[s];
				if (q_head[q] >= SLOTS)
					q_head[q] = s;
				else if (q_tail[q] < SLOTS)
					slot_next[q_tail[q]] = s;
				slot_next[s] = NULL_SLOT;
				q_tail[q] = s;
				slot_word[s] = r.data_in;
			end
		end else begin
			q = r.queue_num - 1;
			s = q_head[q];
			if (s >= SLOTS) begin
				o.status = STAT_EMPTY;
			end else begin
				// unlink head, push the slot onto the front of the free list
				q_head[q] = slot_next[s];
				slot_next[s] = free_slot;
				free_slot = s;
				o.data_out = slot_word[s];
			end
		end
		return o;
	endfunction

	// Appends a request and tracks rough occupancy to steer later bursts.
	function automatic void add_request(logic kind, logic [QNUM_W-1:0] qn,
			logic [DATA_W-1:0] word, bit settle);
		stim_t t;
		t.r.req_type  = kind;
		t.r.queue_num = qn;
		t.r.data_in   = word;
		t.settle      = settle;
		pending.push_back(t);
		if (qn != 0 && qn <= QUEUES) begin
			if (kind == REQ_ENQ && slots_taken < SLOTS) begin
				fill_level[qn]++;
				slots_taken++;
			end else if (kind == REQ_DEQ && fill_level[qn] > 0) begin
				fill_level[qn]--;
				slots_taken--;
			end
		end
	endfunction

	// Driver: records the accepted request, then offers the next one unless
	// idling or waiting for the block to drain.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready) begin
				owed_rsps.push_back(serve_request(req));
				reqs_taken++;
			end
			if (!req_valid || req_ready) begin
				if (pending.size() != 0
						&& !(pending[0].settle && (owed_rsps.size() != 0 || req_valid))
						&& (calm || $urandom_range(99) >= 21)) begin
					req <= pending[0].r;
					req_valid <= 1'b1;
					void'(pending.pop_front());
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every accepted response against the oldest one owed.
	// Once in the run it holds ready low for a long stretch so the block
	// backs up and stalls its request side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (owed_rsps.size() == 0) begin
					$error("response with none owed: data_out %0d status %0d",
						rsp.data_out, rsp.status);
					errors++;
				end else begin
					if (rsp.data_out !== owed_rsps[0].data_out) begin
						$error("data_out: expected %0d, got %0d",
							owed_rsps[0].data_out, rsp.data_out);
						errors++;
					end
					if (rsp.status !== owed_rsps[0].status) begin
						$error("status: expected %0d, got %0d",
							owed_rsps[0].status, rsp.status);
						errors++;
					end
					void'(owed_rsps.pop_front());
				end
			end
			if (!held_once && reqs_taken >= 400) begin
				held_once = 1'b1;
				hold_left = 300;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= calm || $urandom_range(99) >= 21;
			end
		end
	end

	initial begin
		int               mode;
		int               burst;
		int               n;
		logic             kind;
		logic [QNUM_W-1:0] qn;
		logic [DATA_W-1:0] word;

		// reset state: all queues empty, slots chained 0 -> 1 -> ... -> null
		for (int i = 0; i < QUEUES; i++) begin
			q_head[i] = NULL_SLOT;
			q_tail[i] = '0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			slot_next[i] = (i + 1 < SLOTS) ? PTR_W'(i + 1) : NULL_SLOT;
			slot_word[i] = '0;
		end
		free_slot = '0;

		// directed: empty dequeue, word extremes through the lowest and
		// highest queues, rejected queue numbers, then a full store
		add_request(REQ_DEQ, 4'd1, 32'h0000_0000, 1'b0);
		add_request(REQ_ENQ, 4'd1, 32'h7FFF_FFFF, 1'b0);
		add_request(REQ_ENQ, 4'd8, 32'h8000_0000, 1'b0);
		add_request(REQ_ENQ, 4'd1, 32'hFFFF_FFFF, 1'b0);
		add_request(REQ_DEQ, 4'd1, 32'hFFFF_FFFF, 1'b0);
		add_request(REQ_DEQ, 4'd8, 32'h0000_0000, 1'b0);
		add_request(REQ_DEQ, 4'd0, 32'h1234_5678, 1'b0);
		add_request(REQ_ENQ, 4'd9, 32'hDEAD_BEEF, 1'b0);
		add_request(REQ_DEQ, 4'd15, 32'h0000_0001, 1'b0);
		add_request(REQ_ENQ, 4'd0, 32'h0000_0002, 1'b0);
		// one word still sits in queue 1; fill the remaining 15 slots
		for (int i = 0; i < SLOTS - 1; i++)
			add_request(REQ_ENQ, QNUM_W'(i % QUEUES + 1), $urandom, 1'b0);
		add_request(REQ_ENQ, 4'd5, 32'h5555_AAAA, 1'b0);	// store full

		// random bursts: fill-leaning, drain-leaning or mixed
		n = 0;
		while (n < 1825) begin
			mode  = $urandom_range(2);
			burst = $urandom_range(8, 40);
			for (int b = 0; b < burst && n < 1825; b++) begin
				case (mode)
					0: kind = ($urandom_range(99) < 80) ? REQ_ENQ : REQ_DEQ;
					1: kind = ($urandom_range(99) < 80) ? REQ_DEQ : REQ_ENQ;
					default: kind = $urandom_range(1) ? REQ_DEQ : REQ_ENQ;
				endcase
				if ($urandom_range(99) < 10) begin
					// bad queue number: zero or above the queue count
					qn = QNUM_W'($urandom_range(7));
					if (qn != 0)
						qn = QNUM_W'(qn + QUEUES);
				end else begin
					qn = QNUM_W'($urandom_range(1, QUEUES));
					// draining mostly targets queues that hold something
					if (kind == REQ_DEQ && mode == 1 && slots_taken > 0)
						while (fill_level[qn] == 0)
							qn = QNUM_W'($urandom_range(1, QUEUES));
				end
				case ($urandom_range(7))
					0: word = 32'h8000_0000;
					1: word = 32'h7FFF_FFFF;
					2: word = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
					default: word = $urandom;
				endcase
				add_request(kind, qn, word, n == 1300);
				n++;
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || req_valid || owed_rsps.size() != 0)
			@(posedge clk);
		// then wait on to catch any stray response
		repeat (12) @(posedge clk);

		if (errors == 0)
			$display("k_queues_shared_buffer_test: clean");
		else
			$display("k_queues_shared_buffer_test: errors");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("k_queues_shared_buffer_test: errors");
		$finish;
	end

endmodule
